>>> rtl/core/connector_reflection_curve_evaluator_core_defines.svh
// Assertion macros for the connector reflection curve evaluator.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef CONNECTOR_REFLECTION_CURVE_EVALUATOR_CORE_DEFINES_SVH
`define CONNECTOR_REFLECTION_CURVE_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRCE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crce assertion failed");

// Implication after a fixed number of cycles, checked outside reset.
`define CRCE_ASSERT_DELAY(label, ante, lat, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##lat (cons)) \
		else $error("crce assertion failed");

`endif

>>> rtl/core/crce_pkg.sv
// Shared types, constants and tables for the connector reflection curve evaluator.
// No dependencies; every module of the block imports this package.
package crce_pkg;

	// Sample index width: default and largest supported value.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int SAMPLE_BITS_MAX = 24;

	// Width of a nonnegative distance in half-LSB units at the largest sample width.
	localparam int D_W = ((SAMPLE_BITS_MAX + 16 > 32) ? SAMPLE_BITS_MAX + 16 : 32) + 1;

	// Depth of the ratio and exponential unit.
	localparam int DIV_STAGES = 21;
	localparam int EXP_TERMS = 15;
	localparam int POW_STAGES = 23;
	localparam int REX_LAT = 1 + DIV_STAGES + 3 * EXP_TERMS + POW_STAGES;

	// Back part latency from the queue head to the result register.
	localparam int BACK_LAT = REX_LAT + 4;

	// One in Q0.30 and exp(-1) in Q0.30 as the truncated series gives it.
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [28:0] EXP_M1_Q30 = 29'd395007543;

	// Mix fraction of one in Q0.16.
	localparam logic [16:0] MIX_ONE = 17'd65536;

	// Position of a sample relative to the event window.
	typedef enum logic [1:0] {
		RGN_BEFORE,
		RGN_INSIDE,
		RGN_AFTER
	} region_t;

	// Classified word passed from the front part to the back part.
	typedef struct packed {
		logic signed [31:0] level_before;
		logic signed [31:0] level_after;
		logic signed [31:0] jump_height;
		logic [16:0]        mix;
		region_t            region;
		logic [D_W-1:0]     rise_dist;
		logic [D_W-1:0]     fall_dist;
		logic [30:0]        rise_constant;
		logic [30:0]        decay_constant;
		logic [30:0]        tail_constant;
	} crce_work_t;

	// A word with its valid flag.
	typedef struct packed {
		logic       valid;
		crce_work_t work;
	} crce_issue_t;

	// floor(2^32 / k) for the series divisions by the term index.
	function automatic logic [32:0] recip_of(input logic [3:0] k);
		logic [32:0] m;
		unique case (k)
			4'd1:    m = 33'd4294967296;
			4'd2:    m = 33'd2147483648;
			4'd3:    m = 33'd1431655765;
			4'd4:    m = 33'd1073741824;
			4'd5:    m = 33'd858993459;
			4'd6:    m = 33'd715827882;
			4'd7:    m = 33'd613566756;
			4'd8:    m = 33'd536870912;
			4'd9:    m = 33'd477218588;
			4'd10:   m = 33'd429496729;
			4'd11:   m = 33'd390451572;
			4'd12:   m = 33'd357913941;
			4'd13:   m = 33'd330382099;
			4'd14:   m = 33'd306783378;
			4'd15:   m = 33'd286331153;
			default: m = 33'd4294967296;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/core/connector_reflection_curve_evaluator_core.sv
// Top level of the connector reflection curve evaluator: front part, queue, back part.
// Depends on crce_pkg, crce_front, crce_queue, crce_back and the assertion macro header.
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------
//   input     start, busy        level_before .. sample_position, one word
//   result    done               model_level, one word per input word
//
// One word is taken per cycle; each result passes the front stage register, the queue, the
// 90-stage ratio, series and power pipeline of the exponential units and the result stages.
// The back part never stalls, so the queue holds at most one word and busy stays low.
// arst_n clears the valid flags, the queue pointers and the result strobe; no clearing pass.
// Each result is shown for one cycle with done high and must be taken then.
`include "connector_reflection_curve_evaluator_core_defines.svh"

module connector_reflection_curve_evaluator_core import crce_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [31:0]     level_before,
	input  logic signed [31:0]     level_after,
	input  logic signed [31:0]     jump_height,
	input  logic [30:0]            window_width,
	input  logic [30:0]            rise_constant,
	input  logic [30:0]            decay_constant,
	input  logic [16:0]            mix_fraction,
	input  logic [31:0]            event_center,
	input  logic [30:0]            tail_constant,
	input  logic [SAMPLE_BITS-1:0] sample_position,
	output logic                   done,
	output logic signed [31:0]     model_level
);

	localparam int PIPE_LAT = 2 + BACK_LAT;

	logic        accept;
	logic        queue_full;
	crce_issue_t front_issue;
	crce_issue_t queue_head;

	assign accept = start && !busy;
	assign busy   = queue_full;

	// Front part: classification of each word.
	crce_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.level_before    (level_before),
		.level_after     (level_after),
		.jump_height     (jump_height),
		.window_width    (window_width),
		.rise_constant   (rise_constant),
		.decay_constant  (decay_constant),
		.mix_fraction    (mix_fraction),
		.event_center    (event_center),
		.tail_constant   (tail_constant),
		.sample_position (sample_position),
		.issue           (front_issue)
	);

	// Queue between the two parts.
	crce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_word (front_issue),
		.head      (queue_head),
		.full      (queue_full)
	);

	// Back part: exponentials and level arithmetic.
	crce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (queue_head),
		.done        (done),
		.model_level (model_level)
	);

	// Every taken word yields its result after the fixed pipeline latency.
	`CRCE_ASSERT_DELAY(a_result_latency, accept, PIPE_LAT, done)
	// No result appears without a word taken at the matching earlier cycle.
	`CRCE_ASSERT_IMPL(a_result_origin, done, $past(accept, PIPE_LAT))
	// The front part never pushes into a full queue.
	`CRCE_ASSERT_IMPL(a_no_overflow, queue_full, !front_issue.valid)

endmodule

>>> rtl/core/crce_front.sv
// Front part: takes a word, places the sample against the window and forms distances.
// Depends on crce_pkg.
module crce_front import crce_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic signed [31:0]     level_before,
	input  logic signed [31:0]     level_after,
	input  logic signed [31:0]     jump_height,
	input  logic [30:0]            window_width,
	input  logic [30:0]            rise_constant,
	input  logic [30:0]            decay_constant,
	input  logic [16:0]            mix_fraction,
	input  logic [31:0]            event_center,
	input  logic [30:0]            tail_constant,
	input  logic [SAMPLE_BITS-1:0] sample_position,
	output crce_issue_t            issue
);

	localparam int SW = ((SAMPLE_BITS + 16 > 32) ? SAMPLE_BITS + 16 : 32) + 2;

	logic signed [SW-1:0] pos_w;
	logic signed [SW-1:0] ctr_w;
	logic signed [SW-1:0] wid_w;
	logic signed [SW-1:0] span;
	logic signed [SW-1:0] rise_sum;
	logic signed [SW-1:0] fall_sum;
	region_t              region;
	crce_work_t           work;
	logic                 valid_s1;
	crce_work_t           work_s1;

	// Offset from the window center in half-LSB units.
	assign pos_w = $signed({{(SW - SAMPLE_BITS - 16){1'b0}}, sample_position, 16'd0});
	assign ctr_w = $signed({{(SW - 32){1'b0}}, event_center});
	assign wid_w = $signed({{(SW - 31){1'b0}}, window_width});
	assign span  = (pos_w - ctr_w) <<< 1;

	// Window region of the sample.
	always_comb begin
		priority if (span < -wid_w) begin
			region = RGN_BEFORE;
		end else if (span <= wid_w) begin
			region = RGN_INSIDE;
		end else begin
			region = RGN_AFTER;
		end
	end

	// Rise distance is the full window outside it; fall distance counts from its end.
	assign rise_sum = (region == RGN_INSIDE) ? span + wid_w : wid_w <<< 1;
	assign fall_sum = (region == RGN_AFTER) ? span - wid_w : '0;

	always_comb begin
		work.level_before   = level_before;
		work.level_after    = level_after;
		work.jump_height    = jump_height;
		work.mix            = (mix_fraction > MIX_ONE) ? MIX_ONE : mix_fraction;
		work.region         = region;
		work.rise_dist      = D_W'($unsigned(rise_sum));
		work.fall_dist      = D_W'($unsigned(fall_sum));
		work.rise_constant  = rise_constant;
		work.decay_constant = decay_constant;
		work.tail_constant  = tail_constant;
	end

	// Stage register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage register: payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work;
		end
	end

	assign issue.valid = valid_s1;
	assign issue.work  = work_s1;

endmodule

>>> rtl/core/crce_queue.sv
// Two-word queue between the front and back parts.
// Depends on crce_pkg. The back part takes the head word in every cycle that it is present.
module crce_queue import crce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crce_issue_t push_word,
	output crce_issue_t head,
	output logic        full
);

	crce_work_t store_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop = (count_q != 2'd0);

	// Storage write.
	always_ff @(posedge clk) begin
		if (push_word.valid) begin
			store_q[wr_ptr_q] <= push_word.work;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_word.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push_word.valid) - 2'(pop);
		end
	end

	assign head.valid = pop;
	assign head.work  = store_q[rd_ptr_q];
	assign full       = (count_q == 2'd2);

endmodule

>>> rtl/core/crce_ratio_exp.sv
// Pipelined unit: t = (d/2)/c in Q5.16, then exp(-t) in Q0.30.
// Depends on crce_pkg. Restoring divider, truncated series, repeated exp(-1) products.
module crce_ratio_exp import crce_pkg::*; (
	input  logic           clk,
	input  logic [D_W-1:0] half_dist,
	input  logic [30:0]    tconst,
	output logic [30:0]    expo
);

	localparam int CMP_W = (D_W > 37) ? D_W : 37;
	localparam int REM_W = 52;

	typedef struct packed {
		logic [16:0] frac;
		logic [4:0]  whole;
		logic        zero;
	} side_t;

	logic [30:0]             tc_one;
	logic [CMP_W-1:0]        dist_w;
	logic                    ovf;
	logic [REM_W-1:0]        rem_s   [DIV_STAGES+1];
	logic [30:0]             div_c_s [DIV_STAGES+1];
	logic [DIV_STAGES-1:0]   quo_s   [DIV_STAGES+1];
	logic                    ovf_s   [DIV_STAGES+1];
	side_t                   ser_base;
	logic [30:0]             mag_s   [1:EXP_TERMS];
	logic signed [32:0]      sum_s   [1:EXP_TERMS];
	side_t                   side_s  [1:EXP_TERMS];
	logic [30:0]             pow_base;
	logic [30:0]             pow_r_s     [1:POW_STAGES];
	logic [4:0]              pow_whole_s [1:POW_STAGES];
	logic                    pow_zero_s  [1:POW_STAGES];

	// Input stage: a zero constant counts as one LSB; quotients of 2^21 or more give zero.
	assign tc_one = (tconst == '0) ? 31'd1 : tconst;
	assign dist_w = CMP_W'(half_dist);
	assign ovf    = (dist_w >= (CMP_W'(tc_one) << 6));

	always_ff @(posedge clk) begin
		rem_s[0]   <= ovf ? '0 : {dist_w[36:0], 15'd0};
		div_c_s[0] <= tc_one;
		quo_s[0]   <= '0;
		ovf_s[0]   <= ovf;
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
		logic [REM_W-1:0] sub;
		logic             ge;

		assign sub = REM_W'(div_c_s[i-1]) << (DIV_STAGES - i);
		assign ge  = (rem_s[i-1] >= sub);

		always_ff @(posedge clk) begin
			rem_s[i]   <= ge ? rem_s[i-1] - sub : rem_s[i-1];
			div_c_s[i] <= div_c_s[i-1];
			quo_s[i]   <= {quo_s[i-1][DIV_STAGES-2:0], ge};
			ovf_s[i]   <= ovf_s[i-1];
		end
	end

	// Split the quotient into integer and fraction parts.
	always_comb begin
		ser_base.frac  = {1'b0, quo_s[DIV_STAGES][15:0]};
		ser_base.whole = quo_s[DIV_STAGES][20:16];
		ser_base.zero  = ovf_s[DIV_STAGES] || (quo_s[DIV_STAGES][20:16] >= 5'd24);
	end

	// Series of the fraction part: each term is floor(prev * u / 2^16 / k), signs alternate.
	for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
		logic [30:0]        mag_in;
		logic signed [32:0] sum_in;
		side_t              side_in;
		logic [47:0]        prod_a;
		logic [30:0]        v_a;
		logic signed [32:0] sum_a;
		side_t              side_a;
		logic [63:0]        prod_b;
		logic [30:0]        q0_b;
		logic [30:0]        v_b;
		logic signed [32:0] sum_b;
		side_t              side_b;
		logic [34:0]        rem_c;
		logic [30:0]        mag_c;

		if (k == 1) begin : g_first
			assign mag_in  = ONE_Q30;
			assign sum_in  = $signed({2'b00, ONE_Q30});
			assign side_in = ser_base;
		end else begin : g_next
			assign mag_in  = mag_s[k-1];
			assign sum_in  = sum_s[k-1];
			assign side_in = side_s[k-1];
		end

		// Product with the fraction, scaled down by 2^16.
		assign prod_a = 48'(mag_in) * 48'(side_in.frac);

		always_ff @(posedge clk) begin
			v_a    <= prod_a[46:16];
			sum_a  <= sum_in;
			side_a <= side_in;
		end

		// Reciprocal estimate of the division by k; low by at most one.
		assign prod_b = 64'(v_a) * 64'(recip_of(4'(k)));

		always_ff @(posedge clk) begin
			q0_b   <= prod_b[62:32];
			v_b    <= v_a;
			sum_b  <= sum_a;
			side_b <= side_a;
		end

		// Correct the estimate and fold the term into the sum.
		assign rem_c = 35'(v_b) - 35'(q0_b) * 35'(k);
		assign mag_c = (rem_c >= 35'(k)) ? q0_b + 31'd1 : q0_b;

		always_ff @(posedge clk) begin
			mag_s[k]  <= mag_c;
			sum_s[k]  <= ((k % 2) == 1) ? sum_b - $signed({2'b00, mag_c})
			                            : sum_b + $signed({2'b00, mag_c});
			side_s[k] <= side_b;
		end
	end

	// Clamp the series to [0, 1].
	always_comb begin
		priority if (sum_s[EXP_TERMS] < 0) begin
			pow_base = '0;
		end else if (sum_s[EXP_TERMS] > $signed({2'b00, ONE_Q30})) begin
			pow_base = ONE_Q30;
		end else begin
			pow_base = sum_s[EXP_TERMS][30:0];
		end
	end

	// Integer part: stage p multiplies by exp(-1) when p is within the integer part.
	for (genvar p = 1; p <= POW_STAGES; p++) begin : g_pow
		logic [30:0] r_in;
		logic [4:0]  whole_in;
		logic        zero_in;
		logic [59:0] prod;

		if (p == 1) begin : g_first
			assign r_in     = pow_base;
			assign whole_in = side_s[EXP_TERMS].whole;
			assign zero_in  = side_s[EXP_TERMS].zero;
		end else begin : g_next
			assign r_in     = pow_r_s[p-1];
			assign whole_in = pow_whole_s[p-1];
			assign zero_in  = pow_zero_s[p-1];
		end

		assign prod = 60'(r_in) * 60'(EXP_M1_Q30);

		always_ff @(posedge clk) begin
			pow_r_s[p]     <= (5'(p) <= whole_in) ? {1'b0, prod[59:30]} : r_in;
			pow_whole_s[p] <= whole_in;
			pow_zero_s[p]  <= zero_in;
		end
	end

	assign expo = pow_zero_s[POW_STAGES] ? '0 : pow_r_s[POW_STAGES];

endmodule

>>> rtl/core/crce_back.sv
// Back part: three ratio and exponential units, then level mixing, rounding and saturation.
// Depends on crce_pkg and crce_ratio_exp.
module crce_back import crce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  crce_issue_t        head,
	output logic               done,
	output logic signed [31:0] model_level
);

	typedef struct packed {
		logic signed [31:0] level_before;
		logic signed [31:0] level_after;
		logic signed [31:0] jump_height;
		logic [16:0]        mix;
		region_t            region;
	} side_t;

	logic [30:0]         e_rise;
	logic [30:0]         e_decay;
	logic [30:0]         e_tail;
	side_t               line_q [REX_LAT];
	logic [REX_LAT-1:0]  vld_q;
	side_t               tap;
	logic [30:0]         rise_gap;
	logic [31:0]         h_mag;
	logic [62:0]         ph;
	logic [47:0]         pa;
	logic [47:0]         pb;
	logic                vld_s1;
	side_t               side_s1;
	logic [62:0]         ph_s1;
	logic                hneg_s1;
	logic [47:0]         pa_s1;
	logic [47:0]         pb_s1;
	logic [33:0]         rh;
	logic signed [35:0]  a1_x;
	logic signed [35:0]  rh_x;
	logic [48:0]         dsum;
	logic                vld_s2;
	side_t               side_s2;
	logic signed [35:0]  top_s2;
	logic [30:0]         dmix_s2;
	logic signed [35:0]  diff;
	logic [34:0]         dmag;
	logic                vld_s3;
	side_t               side_s3;
	logic signed [35:0]  top_s3;
	logic                dneg_s3;
	logic [47:0]         lo_s3;
	logic [48:0]         hi_s3;
	logic [66:0]         pd;
	logic [36:0]         rd;
	logic signed [37:0]  after_lvl;
	logic signed [37:0]  lvl;
	logic signed [31:0]  sat_lvl;
	logic                done_q;
	logic signed [31:0]  model_level_q;

	// Exponentials of the rise and of both decays.
	crce_ratio_exp u_rise (
		.clk       (clk),
		.half_dist (head.work.rise_dist),
		.tconst    (head.work.rise_constant),
		.expo      (e_rise)
	);

	crce_ratio_exp u_decay (
		.clk       (clk),
		.half_dist (head.work.fall_dist),
		.tconst    (head.work.decay_constant),
		.expo      (e_decay)
	);

	crce_ratio_exp u_tail (
		.clk       (clk),
		.half_dist (head.work.fall_dist),
		.tconst    (head.work.tail_constant),
		.expo      (e_tail)
	);

	// Delay line that keeps the levels beside the exponential units.
	always_ff @(posedge clk) begin
		line_q[0] <= {head.work.level_before, head.work.level_after, head.work.jump_height,
		              head.work.mix, head.work.region};
		for (int i = 1; i < REX_LAT; i++) begin
			line_q[i] <= line_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[REX_LAT-2:0], head.valid};
		end
	end

	assign tap = line_q[REX_LAT-1];

	// Stage 1: jump times (1 - e), and the two weighted decay terms.
	assign rise_gap = ONE_Q30 - e_rise;
	assign h_mag    = tap.jump_height[31] ? ~tap.jump_height + 32'd1 : tap.jump_height;
	assign ph       = 63'(h_mag) * 63'(rise_gap);
	assign pa       = 48'(tap.mix) * 48'(e_decay);
	assign pb       = 48'(MIX_ONE - tap.mix) * 48'(e_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_q[REX_LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= tap;
		ph_s1   <= ph;
		hneg_s1 <= tap.jump_height[31];
		pa_s1   <= pa;
		pb_s1   <= pb;
	end

	// Stage 2: rounded rise gives the window level; the decay mix is rounded to Q0.30.
	assign rh   = 34'(ph_s1[62:30]) + 34'(ph_s1[29]);
	assign a1_x = {{4{side_s1.level_before[31]}}, side_s1.level_before};
	assign rh_x = $signed({2'b00, rh});
	assign dsum = 49'(pa_s1) + 49'(pb_s1) + 49'd32768;

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		top_s2  <= hneg_s1 ? a1_x - rh_x : a1_x + rh_x;
		dmix_s2 <= dsum[46:16];
	end

	// Stage 3: distance to the after level times the mix, in two partial products.
	assign diff = top_s2 - {{4{side_s2.level_after[31]}}, side_s2.level_after};
	assign dmag = diff[35] ? 35'(-diff) : 35'(diff);

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		top_s3  <= top_s2;
		dneg_s3 <= diff[35];
		lo_s3   <= 48'(dmag[16:0]) * 48'(dmix_s2);
		hi_s3   <= 49'(dmag[34:17]) * 49'(dmix_s2);
	end

	// Stage 4: combine, round, pick the region's level and saturate.
	assign pd        = (67'(hi_s3) << 17) + 67'(lo_s3);
	assign rd        = 37'(pd[66:30]) + 37'(pd[29]);
	assign after_lvl = dneg_s3
		? {{6{side_s3.level_after[31]}}, side_s3.level_after} - $signed({1'b0, rd})
		: {{6{side_s3.level_after[31]}}, side_s3.level_after} + $signed({1'b0, rd});

	always_comb begin
		unique case (side_s3.region)
			RGN_BEFORE: lvl = {{6{side_s3.level_before[31]}}, side_s3.level_before};
			RGN_INSIDE: lvl = {{2{top_s3[35]}}, top_s3};
			RGN_AFTER:  lvl = after_lvl;
			default:    lvl = {{6{side_s3.level_before[31]}}, side_s3.level_before};
		endcase
	end

	always_comb begin
		priority if (lvl > 38'sd2147483647) begin
			sat_lvl = 32'sh7FFF_FFFF;
		end else if (lvl < -38'sd2147483648) begin
			sat_lvl = 32'sh8000_0000;
		end else begin
			sat_lvl = lvl[31:0];
		end
	end

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		model_level_q <= sat_lvl;
	end

	assign done        = done_q;
	assign model_level = model_level_q;

endmodule

>>> bench/tb_top.sv
// Testbench for connector_reflection_curve_evaluator_core: directed table, then random words.
// Depends on crce_pkg and the core RTL; each result is compared with its table level or a built-in level predictor.
module tb_top;
	import crce_pkg::*;

	// One input word as driven on the ports.
	typedef struct {
		logic signed [31:0] level_before;
		logic signed [31:0] level_after;
		logic signed [31:0] jump_height;
		logic [30:0]        window_width;
		logic [30:0]        rise_constant;
		logic [30:0]        decay_constant;
		logic [16:0]        mix_fraction;
		logic [31:0]        event_center;
		logic [30:0]        tail_constant;
		logic [15:0]        sample_position;
	} event_word_t;

	// A directed row: the word and, where obvious, its level.
	typedef struct {
		event_word_t        word;
		bit                 known;
		logic signed [31:0] level;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic signed [31:0] model_level;
	event_word_t        drive_word;

	logic signed [31:0] expected_levels[$];
	logic signed [31:0] pending_level;
	int                 accepted_words;
	int                 mismatch_count;
	int                 sender_idle_pct;
	table_row_t         directed_rows[$];

	connector_reflection_curve_evaluator_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.level_before   (drive_word.level_before),
		.level_after    (drive_word.level_after),
		.jump_height    (drive_word.jump_height),
		.window_width   (drive_word.window_width),
		.rise_constant  (drive_word.rise_constant),
		.decay_constant (drive_word.decay_constant),
		.mix_fraction   (drive_word.mix_fraction),
		.event_center   (drive_word.event_center),
		.tail_constant  (drive_word.tail_constant),
		.sample_position(drive_word.sample_position),
		.done           (done),
		.model_level    (model_level)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// exp(-u/2^16) in Q0.30 by a truncated Taylor series, u in [0, 2^16].
	function automatic longint exp_frac_q30(input longint u);
		longint term;
		longint sum;
		term = longint'(1) << 30;
		sum = term;
		for (int k = 1; k <= 15; k++) begin
			term = -(term * u) / (longint'(65536) * k);
			sum += term;
		end
		if (sum < 0)
			sum = 0;
		if (sum > (longint'(1) << 30))
			sum = longint'(1) << 30;
		return sum;
	endfunction

	// exp(-t) in Q0.30 for t in unsigned Q48.16: whole part by repeated products.
	function automatic longint decay_factor(input bit [63:0] t);
		bit [63:0] whole;
		bit [63:0] r;
		bit [63:0] e1;
		whole = t >> 16;
		if (whole >= 24)
			return 0;
		r = exp_frac_q30(longint'(t & 64'hFFFF));
		e1 = exp_frac_q30(65536);
		for (int i = 0; i < whole; i++)
			r = (r * e1) >> 30;
		return longint'(r);
	endfunction

	// Half-LSB distance over a time constant in Q48.16; zero counts as one LSB.
	function automatic bit [63:0] distance_ratio(input bit [63:0] d, input bit [63:0] c);
		if (c == 0)
			c = 1;
		return (d << 15) / c;
	endfunction

	// v*q/2^30 rounded half away from zero.
	function automatic longint scale_q30(input longint v, input bit [63:0] q);
		bit [63:0] mag;
		bit [63:0] p;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		p = mag * q;
		p = (p >> 30) + ((p >> 29) & 64'd1);
		return (v < 0) ? -longint'(p) : longint'(p);
	endfunction

	// Saturated model level for one word.
	function automatic logic signed [31:0] predict_level(input event_word_t w);
		longint a1, a2, h, wd, c, s, lvl, top;
		bit [63:0] mix, ew, ea, eb, d2, dmix;
		a1 = longint'(w.level_before);
		a2 = longint'(w.level_after);
		h = longint'(w.jump_height);
		wd = longint'({1'b0, w.window_width});
		c = longint'({1'b0, w.event_center});
		mix = w.mix_fraction;
		s = 2 * ((longint'({1'b0, w.sample_position}) << 16) - c);
		if (mix > 65536)
			mix = 65536;
		if (s < -wd) begin
			lvl = a1;
		end else if (s <= wd) begin
			ew = decay_factor(distance_ratio(64'(s + wd), w.rise_constant));
			lvl = a1 + scale_q30(h, (64'd1 << 30) - ew);
		end else begin
			ew = decay_factor(distance_ratio(64'(2 * wd), w.rise_constant));
			top = a1 + scale_q30(h, (64'd1 << 30) - ew);
			d2 = 64'(s - wd);
			ea = decay_factor(distance_ratio(d2, w.decay_constant));
			eb = decay_factor(distance_ratio(d2, w.tail_constant));
			dmix = (mix * ea + (64'd65536 - mix) * eb + 64'd32768) >> 16;
			lvl = a2 + scale_q30(top - a2, dmix);
		end
		if (lvl > 64'sd2147483647)
			lvl = 64'sd2147483647;
		if (lvl < -64'sd2147483648)
			lvl = -64'sd2147483648;
		return lvl[31:0];
	endfunction

	function automatic event_word_t make_word(input logic [31:0] a1, input logic [31:0] a2,
			input logic [31:0] h, input logic [30:0] wd, input logic [30:0] rc,
			input logic [30:0] dc, input logic [16:0] m, input logic [31:0] c,
			input logic [30:0] tc, input logic [15:0] x);
		event_word_t w;
		w.level_before = a1;
		w.level_after = a2;
		w.jump_height = h;
		w.window_width = wd;
		w.rise_constant = rc;
		w.decay_constant = dc;
		w.mix_fraction = m;
		w.event_center = c;
		w.tail_constant = tc;
		w.sample_position = x;
		return w;
	endfunction

	// Random word: mostly samples near the event with usable constants, some full noise.
	function automatic event_word_t random_word();
		event_word_t w;
		logic [15:0] x;
		int          offset;
		w = make_word($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
			31'($urandom), 17'($urandom), $urandom, 31'($urandom), 16'($urandom));
		if ($urandom_range(99) < 80) begin
			x = 16'($urandom);
			offset = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			w.event_center = 32'((longint'(x) << 16) - offset);
			w.window_width = 31'($urandom_range(0, 1 << 23));
			w.rise_constant = 31'($urandom_range(1, 1 << 22));
			w.decay_constant = 31'($urandom_range(1, 1 << 22));
			w.tail_constant = 31'($urandom_range(1, 1 << 23));
			w.mix_fraction = 17'($urandom_range(0, 65536));
			w.sample_position = x;
			if ($urandom_range(1)) begin
				w.level_before = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				w.level_after = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				w.jump_height = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			end
		end
		return w;
	endfunction

	// Acceptance and result checking at the rising edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_levels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: level %0d", model_level);
			end else begin
				pending_level = expected_levels.pop_front();
				if (model_level !== pending_level) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("level mismatch: expected %0d, got %0d",
							pending_level, model_level);
				end
			end
		end
		if (arst_n && start && !busy)
			accepted_words++;
	end

	// Offer one word until taken; random idle cycles before it.
	task automatic send_word(input event_word_t w, input bit known,
			input logic signed [31:0] level);
		int taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		drive_word = w;
		start = 1'b1;
		taken = accepted_words;
		expected_levels.push_back(known ? level : predict_level(w));
		@(negedge clk);
		while (accepted_words == taken)
			@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain_results();
		while (expected_levels.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(input event_word_t w, input bit known,
			input logic signed [31:0] level);
		table_row_t r;
		r.word = w;
		r.known = known;
		r.level = level;
		directed_rows.push_back(r);
	endtask

	initial begin
		start = 1'b0;
		arst_n = 1'b0;
		drive_word = make_word(0, 0, 0, 0, 1, 1, 0, 0, 1, 0);
		accepted_words = 0;
		mismatch_count = 0;
		sender_idle_pct = 0;

		// Before the window: the base level, at both extremes.
		add_row(make_word(32'h7FFF_FFFF, 0, 32'h8000_0000, 31'h100, 1, 1, 0,
			32'hFFFF_FFFF, 1, 0), 1, 32'sh7FFF_FFFF);
		add_row(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFE), 1,
			32'sh8000_0000);
		// Zero width exactly at the center: the base level.
		add_row(make_word(32'h0001_2345, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 1, 0,
			32'h0005_0000, 1, 16'd5), 1, 32'sh0001_2345);
		// Inside the window, rising both ways, zero rise constant.
		add_row(make_word(32'h0001_0000, 0, 32'h0004_0000, 31'h0008_0000, 31'h0002_0000,
			1, 0, 32'h0010_0000, 1, 16'd16), 0, 0);
		add_row(make_word(32'h0001_0000, 0, 32'hFFFC_0000, 31'h0008_0000, 0,
			1, 0, 32'h0010_0000, 1, 16'd17), 0, 0);
		add_row(make_word(32'h7FFF_0000, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1,
			1, 0, 32'h0000_8000, 1, 16'd0), 1, 32'sh7FFF_FFFF);
		add_row(make_word(32'h8000_0000, 0, 32'h8000_0000, 31'h7FFF_FFFF, 1,
			1, 0, 32'h0000_8000, 1, 16'd0), 1, 32'sh8000_0000);
		// After the window: mix extremes, clamped mix; at the window end, zero decay constants.
		add_row(make_word(0, 32'h0002_0000, 32'h0005_0000, 31'h0002_0000, 31'h0001_0000,
			31'h0003_0000, 17'd0, 32'h0010_0000, 31'h0008_0000, 16'd18), 0, 0);
		add_row(make_word(0, 32'h0002_0000, 32'h0005_0000, 31'h0002_0000, 31'h0001_0000,
			31'h0003_0000, 17'd65536, 32'h0010_0000, 31'h0008_0000, 16'd18), 0, 0);
		add_row(make_word(0, 32'h0002_0000, 32'h0005_0000, 31'h0002_0000, 31'h0001_0000,
			31'h0003_0000, 17'h1FFFF, 32'h0010_0000, 31'h0008_0000, 16'd18), 0, 0);
		add_row(make_word(0, 32'hFFFE_0000, 32'h0005_0000, 31'h0002_0000, 31'h0001_0000,
			0, 17'd32768, 32'h0010_0000, 0, 16'd17), 0, 0);
		// Far after the window: the after level, at both extremes.
		add_row(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1,
			17'd30000, 0, 1, 16'hFFFF), 1, 32'sh7FFF_FFFF);
		add_row(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 1,
			17'd30000, 0, 1, 16'hFFFF), 1, 32'sh8000_0000);
		// Wide intermediates: the after part overshoots and saturates.
		add_row(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0004_0000,
			31'h0000_1000, 31'h7FFF_FFFF, 17'd65536, 32'h0010_0000, 31'h7FFF_FFFF,
			16'd19), 0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].level);

		// Three idle profiles; the sender waits for every result between them.
		for (int phase = 0; phase < 3; phase++) begin
			drain_results();
			sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
			for (int n = 0; n < 600; n++) begin
				if (($urandom_range(99) < 3) && (phase != 1)) begin
					start = 1'b0;
					repeat ($urandom_range(1, 20)) @(negedge clk);
				end
				send_word(random_word(), 0, 0);
			end
		end

		drain_results();
		repeat (BACK_LAT + 20) @(negedge clk);
		if (mismatch_count == 0 && expected_levels.size() == 0)
			$display("connector_reflection_curve_evaluator_core: match");
		else
			$display("connector_reflection_curve_evaluator_core: mismatch");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#5000000;
		$display("connector_reflection_curve_evaluator_core: mismatch");
		$finish;
	end

endmodule
